/* hw/rtl/rtsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtsi_pkg;

	localparam int DEF_TABLE_DEPTH = 256;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int BASE_W    = 16;
	localparam int COUNT_W   = 9;
	localparam int INDEX_W   = 8;
	localparam int READING_W = 16;
	localparam int TEMP_W    = 16;

	localparam logic REG_TEMP_BASE      = 1'b0;
	localparam logic REG_ENTRIES_IN_USE = 1'b1;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/rtsi_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtsi_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	output logic      [NUM_W-1:0]  quo,
	output rtsi_pkg::div_stat_t    stat
);
	import rtsi_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_sh - {1'b0, den_q};
			end else begin
				rem_q <= rem_sh;
			end
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/rtd_table_search_interpolate.sv */
// Load item: writes one table entry, gives no result.
// Convert item: a sample below the first entry or above the last gives an out of range result;
// otherwise the result follows the binary search over the single table read port and the
// bit-serial divider.
// One item is in work at a time; the next is accepted once the result is registered.
// Reset is asynchronous and active low; the table is not cleared and must be loaded.
`timescale 1ns / 1ps
`default_nettype none

module rtd_table_search_interpolate #(
	parameter int TABLE_DEPTH = rtsi_pkg::DEF_TABLE_DEPTH,
	parameter int SAMPLE_BITS = rtsi_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// entry_index [7:0], entry_value [23:8], sample [39:24]
	input  wire logic [39:0] s_axis_tdata,
	// command [0]
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// temperature [15:0]
	output logic [15:0]      m_axis_tdata,
	// out_of_range [0], saturated [1]
	output logic [1:0]       m_axis_tuser
);
	import rtsi_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int SB   = SAMPLE_BITS;
	localparam int NW   = SB + 4;
	localparam int CW   = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
	localparam int MW   = (NW > AW + 4) ? NW : AW + 4;
	localparam int TW   = ((MW > BASE_W) ? MW : BASE_W) + 2;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD0   = 4'd1;
	localparam logic [3:0] ST_CHK0  = 4'd2;
	localparam logic [3:0] ST_CHKL  = 4'd3;
	localparam logic [3:0] ST_PROBE = 4'd4;
	localparam logic [3:0] ST_WAITP = 4'd5;
	localparam logic [3:0] ST_CMPP  = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_WL    = 4'd8;
	localparam logic [3:0] ST_LOC   = 4'd9;
	localparam logic [3:0] ST_HIC   = 4'd10;
	localparam logic [3:0] ST_DIV   = 4'd11;
	localparam logic [3:0] ST_SUM   = 4'd12;

	logic [BASE_W-1:0]  temp_base_q;
	logic [COUNT_W-1:0] entries_q;

	logic [3:0]    state_q;
	logic [SB-1:0] s_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] mask_q;
	logic [AW-1:0] addr_q;
	logic [SB-1:0] rd_data_q;
	logic [SB-1:0] lo_q;
	logic          gt_lo_q;
	logic          oor_q;
	logic [NW-1:0] frac_q;

	logic [15:0]   out_temp_q;
	logic          out_oor_q;
	logic          out_sat_q;
	logic          m_tvalid_q;

	logic [SB-1:0] mem [TABLE_DEPTH];

	logic          cfg_wr;
	logic          in_acc;
	logic          load_wr;
	logic [7:0]    in_eidx;
	logic [SB-1:0] in_eval;
	logic [SB-1:0] in_sample;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] cnt_clamp;
	logic [AW-1:0] last_d;
	logic [AW-1:0] probe;
	logic          cmp_lt;
	logic          cmp_eq;
	logic          div_start;
	logic [NW-1:0] div_num;
	logic [NW-1:0] div_quo;
	div_stat_t     div_st;
	logic          out_free;

	logic [AW+3:0]        idx10;
	logic signed [TW-1:0] t_sum;
	logic                 sat_hi;
	logic                 sat_lo;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_TEMP_BASE:      prdata = {16'd0, temp_base_q};
			REG_ENTRIES_IN_USE: prdata = {23'd0, entries_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_base_q <= '0;
			entries_q   <= ENTRIES_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TEMP_BASE:      temp_base_q <= pwdata[BASE_W-1:0];
				REG_ENTRIES_IN_USE: entries_q   <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_eidx   = s_axis_tdata[7:0];
	assign in_eval   = SB'(s_axis_tdata[23:8]);
	assign in_sample = SB'(s_axis_tdata[39:24]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_wr       = in_acc && (s_axis_tuser == CMD_LOAD)
		&& ({24'd0, in_eidx} < 32'(TABLE_DEPTH));

	always_comb begin
		cnt_ext   = CW'(entries_q);
		cnt_clamp = cnt_ext;
		if (cnt_ext < CW'(2)) begin
			cnt_clamp = CW'(2);
		end else if (cnt_ext > CW'(TABLE_DEPTH)) begin
			cnt_clamp = CW'(TABLE_DEPTH);
		end
		last_d = AW'(cnt_clamp - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[AW'(in_eidx)] <= in_eval;
		end
		rd_data_q <= mem[addr_q];
	end

	assign cmp_lt = s_q < rd_data_q;
	assign cmp_eq = s_q == rd_data_q;
	assign probe  = idx_q | mask_q;

	assign div_start = (state_q == ST_HIC) && gt_lo_q && (rd_data_q > lo_q);
	assign div_num   = NW'(({4'd0, s_q - lo_q} << 3) + ({4'd0, s_q - lo_q} << 1));

	rtsi_div #(
		.NUM_W (NW),
		.DEN_W (SB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (rd_data_q - lo_q),
		.quo    (div_quo),
		.stat   (div_st)
	);

	assign idx10 = ((AW + 4)'(idx_q) << 3) + ((AW + 4)'(idx_q) << 1);
	assign t_sum = TW'(signed'(temp_base_q)) + signed'(TW'(idx10)) + signed'(TW'(frac_q));
	assign sat_hi = t_sum > TW'(32767);
	assign sat_lo = t_sum < -TW'(32768);

	assign out_free = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_SUM) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mask_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == CMD_CONVERT)) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0:  state_q <= ST_CHK0;
				ST_CHK0: state_q <= cmp_lt ? ST_SUM : ST_CHKL;
				ST_CHKL: begin
					if (!cmp_lt && !cmp_eq) begin
						state_q <= ST_SUM;
					end else begin
						mask_q  <= AW'(1) << (AW - 1);
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (mask_q == '0) begin
						state_q <= ST_FIN;
					end else if (probe <= last_q) begin
						state_q <= ST_WAITP;
					end else begin
						mask_q <= mask_q >> 1;
					end
				end
				ST_WAITP: state_q <= ST_CMPP;
				ST_CMPP: begin
					if (cmp_eq) begin
						mask_q  <= '0;
						state_q <= ST_SUM;
					end else begin
						mask_q  <= mask_q >> 1;
						state_q <= ST_PROBE;
					end
				end
				ST_FIN:  state_q <= (idx_q == last_q) ? ST_SUM : ST_WL;
				ST_WL:   state_q <= ST_LOC;
				ST_LOC:  state_q <= ST_HIC;
				ST_HIC:  state_q <= div_start ? ST_DIV : ST_SUM;
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q    <= in_sample;
				last_q <= last_d;
				addr_q <= '0;
				idx_q  <= '0;
				oor_q  <= 1'b0;
				frac_q <= '0;
			end
			ST_RD0:  addr_q <= last_q;
			ST_CHK0: oor_q <= cmp_lt;
			ST_CHKL: oor_q <= !cmp_lt && !cmp_eq;
			ST_PROBE: begin
				if ((mask_q != '0) && (probe <= last_q)) begin
					addr_q <= probe;
				end
			end
			ST_CMPP: begin
				if (cmp_eq || !cmp_lt) begin
					idx_q <= addr_q;
				end
			end
			ST_FIN:  addr_q <= idx_q;
			ST_WL:   addr_q <= AW'(idx_q + 1'b1);
			ST_LOC: begin
				lo_q    <= rd_data_q;
				gt_lo_q <= !cmp_lt && !cmp_eq;
			end
			ST_DIV: begin
				if (div_st.done) begin
					frac_q <= div_quo;
				end
			end
			ST_SUM: begin
				if (out_free) begin
					out_oor_q <= oor_q;
					if (oor_q) begin
						out_temp_q <= '0;
						out_sat_q  <= 1'b0;
					end else if (sat_hi) begin
						out_temp_q <= 16'h7FFF;
						out_sat_q  <= 1'b1;
					end else if (sat_lo) begin
						out_temp_q <= 16'h8000;
						out_sat_q  <= 1'b1;
					end else begin
						out_temp_q <= t_sum[TEMP_W-1:0];
						out_sat_q  <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = out_temp_q;
	assign m_axis_tuser  = {out_sat_q, out_oor_q};

	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
		else $error("out of range result carries a temperature or saturation");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_axis_tuser == CMD_LOAD) && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("load item produced a result");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == ST_DIV))
		else $error("divider running outside the divide step");

	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(mask_q))
		else $error("search mask has more than one bit set");

endmodule

`default_nettype wire

/* dv/temp_conversion_checker.sv */
`timescale 1ns / 1ps

module temp_conversion_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        s_valid,
	input  wire logic        s_ready,
	// entry_index [7:0], entry_value [23:8], sample [39:24]
	input  wire logic [39:0] s_data,
	// command [0]
	input  wire logic        s_user,
	input  wire logic        m_valid,
	input  wire logic        m_ready,
	// temperature [15:0]
	input  wire logic [15:0] m_data,
	// out_of_range [0], saturated [1]
	input  wire logic [1:0]  m_user,
	output int               outstanding,
	output int               error_count
);

	typedef struct packed {
		logic [15:0] temp;
		logic        out_of_range;
		logic        saturated;
	} temp_result_t;

	logic [15:0]  readings [256];
	logic [15:0]  base_reg;
	logic [8:0]   count_reg;
	temp_result_t pending_temps [$];
	int           errs = 0;

	function automatic temp_result_t convert_reading(input logic [15:0] s);
		temp_result_t r;
		int n, last, mask, idx, frac, t, lo, hi;
		logic exact;
		r = '0;
		exact = 1'b0;
		frac = 0;
		n = count_reg;
		if (n < 2) n = 2;
		if (n > 256) n = 256;
		last = n - 1;
		if (s < readings[0] || s > readings[last]) begin
			r.out_of_range = 1'b1;
			return r;
		end
		mask = 1;
		while ((mask << 1) <= last) mask = mask << 1;
		idx = 0;
		while (mask != 0 && !exact) begin
			if ((idx | mask) <= last) begin
				idx = idx | mask;
				if (s == readings[idx]) exact = 1'b1;
				else if (s < readings[idx]) idx = idx & ~mask;
			end
			mask = mask >> 1;
		end
		if (!exact && s > readings[idx] && idx + 1 < n) begin
			lo = readings[idx];
			hi = readings[idx + 1];
			if (hi > lo) frac = (10 * (int'(s) - lo)) / (hi - lo);
		end
		t = int'($signed(base_reg)) + 10 * idx + frac;
		if (t > 32767) begin
			t = 32767;
			r.saturated = 1'b1;
		end
		if (t < -32768) begin
			t = -32768;
			r.saturated = 1'b1;
		end
		r.temp = t[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		temp_result_t want;
		if (!arst_n) begin
			base_reg = '0;
			count_reg = rtsi_pkg::ENTRIES_RESET;
			pending_temps.delete();
			outstanding <= 0;
			error_count <= errs;
		end else begin
			if (m_valid && m_ready) begin
				if (pending_temps.size() == 0) begin
					errs++;
					$display("%0t: unexpected item, expected none, got temp %0d user %b",
						$time, $signed(m_data), m_user);
				end else begin
					want = pending_temps.pop_front();
					if (m_data !== want.temp) begin
						errs++;
						$display("%0t: temperature expected %0d got %0d",
							$time, $signed(want.temp), $signed(m_data));
					end
					if (m_user[0] !== want.out_of_range) begin
						errs++;
						$display("%0t: out_of_range expected %b got %b",
							$time, want.out_of_range, m_user[0]);
					end
					if (m_user[1] !== want.saturated) begin
						errs++;
						$display("%0t: saturated expected %b got %b",
							$time, want.saturated, m_user[1]);
					end
				end
			end
			if (s_valid && s_ready) begin
				if (s_user == rtsi_pkg::CMD_LOAD) readings[s_data[7:0]] = s_data[23:8];
				else pending_temps.push_back(convert_reading(s_data[39:24]));
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == rtsi_pkg::REG_TEMP_BASE) base_reg = pwdata[15:0];
				else count_reg = pwdata[8:0];
			end
			outstanding <= pending_temps.size();
			error_count <= errs;
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int          outstanding;
	int          error_count;
	int          send_idle_pct = 14;
	int          recv_idle_pct = 49;
	int          stall_cycles = 0;
	int          used_n = 256;
	logic [15:0] shadow_tab [256];

	rtd_table_search_interpolate DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	temp_conversion_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_data      (s_axis_tdata),
		.s_user      (s_axis_tuser),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata),
		.m_user      (m_axis_tuser),
		.outstanding (outstanding),
		.error_count (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// A requested stall holds the output off for a long stretch so that the
	// block fills up and has to refuse new items.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				m_axis_tready <= 1'b0;
				stall_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [15:0] val,
		input logic [15:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {smp, val, idx};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [15:0] val);
		send_item(rtsi_pkg::CMD_LOAD, idx, val, 16'($urandom));
		shadow_tab[idx] = val;
	endtask

	task automatic convert(input logic [15:0] smp);
		send_item(rtsi_pkg::CMD_CONVERT, 8'($urandom), 16'($urandom), smp);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic set_config(input int base, input int count);
		drain();
		write_reg(rtsi_pkg::REG_TEMP_BASE, 32'(base));
		write_reg(rtsi_pkg::REG_ENTRIES_IN_USE, 32'(count));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		used_n = count < 2 ? 2 : (count > 256 ? 256 : count);
	endtask

	function automatic logic [15:0] pick_sample();
		int k, lo, hi, pick;
		k = $urandom_range(used_n - 2, 0);
		lo = shadow_tab[k];
		hi = shadow_tab[k + 1];
		if (lo > hi) begin
			pick = lo;
			lo = hi;
			hi = pick;
		end
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: return 16'($urandom_range(hi, lo));
			4, 5: return $urandom_range(1) ? shadow_tab[k] : shadow_tab[used_n - 1];
			6: return $urandom_range(1) ? shadow_tab[0] - 16'd1 : shadow_tab[used_n - 1] + 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// Most loads keep the table rising by landing between the neighbors.
	task automatic random_item();
		logic [7:0] idx;
		int lo, hi;
		if ($urandom_range(99) < 15) begin
			idx = 8'($urandom);
			if (idx != 0 && idx != 255 && $urandom_range(9) < 6) begin
				lo = shadow_tab[idx - 1];
				hi = shadow_tab[idx + 1];
				load_entry(idx, 16'($urandom_range(hi, lo)));
			end else begin
				load_entry(idx, 16'($urandom));
			end
		end else begin
			convert(pick_sample());
		end
	endtask

	initial begin
		int base_vals [9];
		int count_vals [9];
		logic [15:0] v;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = rtsi_pkg::CMD_LOAD;
		base_vals = '{0, 32767, -32768, 1000, -500, 0, 32000, 0, -2000};
		count_vals = '{256, 2, 17, 0, 1, 511, 100, 257, 0};
		base_vals[5] = int'($signed(16'($urandom)));
		base_vals[7] = int'($signed(16'($urandom)));
		count_vals[8] = $urandom_range(256, 2);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 256; i++) begin
			v = 16'(i * 257 - ((i == 0 || i == 255) ? 0 : $urandom_range(100)));
			load_entry(8'(i), v);
		end

		convert(16'h0000);
		convert(16'hFFFF);
		convert(shadow_tab[128]);
		convert(16'((int'(shadow_tab[77]) + int'(shadow_tab[78])) / 2));
		convert(shadow_tab[200] - 16'd1);
		convert(shadow_tab[1] - 16'd1);
		set_config(32767, 256);
		convert(16'hFFFF);
		convert(16'h0000);
		set_config(-32768, 511);
		convert(16'h0000);
		convert(16'hFFFF);
		convert(shadow_tab[3] + 16'd5);
		set_config(0, 2);
		convert(shadow_tab[1] + 16'd1);
		convert(shadow_tab[1]);
		convert(shadow_tab[0] + 16'd1);
		set_config(0, 1);
		convert(shadow_tab[1]);
		load_entry(8'd0, 16'd300);
		convert(16'd299);
		convert(16'd300);
		load_entry(8'd10, shadow_tab[9]);
		load_entry(8'd20, 16'hFFFF);
		set_config(0, 256);
		convert(shadow_tab[9]);
		convert(shadow_tab[19] + 16'd1);

		for (int seg = 0; seg < 9; seg++) begin
			send_idle_pct = seg < 3 ? 14 : (seg < 6 ? 49 : 0);
			recv_idle_pct = seg < 3 ? 49 : (seg < 6 ? 14 : 0);
			set_config(base_vals[seg], count_vals[seg]);
			if (seg == 4) stall_cycles = 300;
			repeat (19) random_item();
		end

		drain();
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
